>>> rtl/core/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, key codes and the scan code to ASCII table for the
// scan code set 1 line editor.
// ----------------------------------------------------------------------------
package sc2a_pkg;

	// default depth of the line store
	localparam int LINE_DEPTH_DEF = 128;

	// command modes carried by the input transaction
	typedef enum logic [1:0] {
		MODE_SCAN    = 2'd0,
		MODE_READ    = 2'd1,
		MODE_CONSUME = 2'd2
	} mode_t;

	// scan code set 1 key codes
	localparam logic [7:0] CODE_CTRL_DOWN   = 8'h1D;
	localparam logic [7:0] CODE_CTRL_UP     = 8'h9D;
	localparam logic [7:0] CODE_LSHIFT_DOWN = 8'h2A;
	localparam logic [7:0] CODE_LSHIFT_UP   = 8'hAA;
	localparam logic [7:0] CODE_RSHIFT_DOWN = 8'h36;
	localparam logic [7:0] CODE_RSHIFT_UP   = 8'hB6;
	localparam logic [7:0] CODE_ALT_DOWN    = 8'h38;
	localparam logic [7:0] CODE_ALT_UP      = 8'hB8;
	localparam logic [7:0] CODE_CAPS_DOWN   = 8'h3A;
	localparam logic [7:0] CODE_BKSP_DOWN   = 8'h0E;
	localparam logic [7:0] CODE_TAB_DOWN    = 8'h0F;
	localparam logic [7:0] CODE_F1_DOWN     = 8'h3B;
	localparam logic [7:0] CODE_F3_DOWN     = 8'h3D;
	localparam logic [7:0] CODE_MAP_FIRST   = 8'h02;
	localparam logic [7:0] CODE_MAP_SIZE    = 8'd59;

	// characters with a special role
	localparam logic [6:0] CH_BS = 7'h08;
	localparam logic [6:0] CH_NL = 7'h0A;
	localparam logic [6:0] CH_L  = 7'h6C;

	// decoded key event handed from the key decoder to the line editor
	typedef struct packed {
		logic       is_char;
		logic [6:0] ch;
		logic       bksp;
		logic       clear;
		logic       sw_valid;
		logic [1:0] sw_target;
	} key_evt_t;

	// line editor outcome for one transaction
	typedef struct packed {
		logic       echo_valid;
		logic [6:0] echo_char;
		logic       line_ready;
		logic       read_sel;
	} line_res_t;

	// letter keys, where caps lock flips shift
	function automatic logic is_letter(input logic [5:0] code);
		return (code >= 6'h10 && code <= 6'h19) || (code >= 6'h1E && code <= 6'h26) ||
			(code >= 6'h2C && code <= 6'h32);
	endfunction

	// unshifted and shifted ASCII for codes below the table size
	function automatic logic [6:0] key_map(input logic [5:0] code, input logic shifted);
		logic [6:0] lo;
		logic [6:0] hi;
		lo = 7'h00;
		hi = 7'h00;
		unique case (code)
			6'd2:  begin lo = 7'h31; hi = 7'h21; end
			6'd3:  begin lo = 7'h32; hi = 7'h40; end
			6'd4:  begin lo = 7'h33; hi = 7'h23; end
			6'd5:  begin lo = 7'h34; hi = 7'h24; end
			6'd6:  begin lo = 7'h35; hi = 7'h25; end
			6'd7:  begin lo = 7'h36; hi = 7'h5E; end
			6'd8:  begin lo = 7'h37; hi = 7'h26; end
			6'd9:  begin lo = 7'h38; hi = 7'h2A; end
			6'd10: begin lo = 7'h39; hi = 7'h28; end
			6'd11: begin lo = 7'h30; hi = 7'h29; end
			6'd12: begin lo = 7'h2D; hi = 7'h5F; end
			6'd13: begin lo = 7'h3D; hi = 7'h2B; end
			6'd14: begin lo = 7'h08; hi = 7'h08; end
			6'd15: begin lo = 7'h09; hi = 7'h09; end
			6'd16: begin lo = 7'h71; hi = 7'h51; end
			6'd17: begin lo = 7'h77; hi = 7'h57; end
			6'd18: begin lo = 7'h65; hi = 7'h45; end
			6'd19: begin lo = 7'h72; hi = 7'h52; end
			6'd20: begin lo = 7'h74; hi = 7'h54; end
			6'd21: begin lo = 7'h79; hi = 7'h59; end
			6'd22: begin lo = 7'h75; hi = 7'h55; end
			6'd23: begin lo = 7'h69; hi = 7'h49; end
			6'd24: begin lo = 7'h6F; hi = 7'h4F; end
			6'd25: begin lo = 7'h70; hi = 7'h50; end
			6'd26: begin lo = 7'h5B; hi = 7'h7B; end
			6'd27: begin lo = 7'h5D; hi = 7'h7D; end
			6'd28: begin lo = 7'h0A; hi = 7'h0A; end
			6'd29: begin lo = 7'h30; hi = 7'h30; end
			6'd30: begin lo = 7'h61; hi = 7'h41; end
			6'd31: begin lo = 7'h73; hi = 7'h53; end
			6'd32: begin lo = 7'h64; hi = 7'h44; end
			6'd33: begin lo = 7'h66; hi = 7'h46; end
			6'd34: begin lo = 7'h67; hi = 7'h47; end
			6'd35: begin lo = 7'h68; hi = 7'h48; end
			6'd36: begin lo = 7'h6A; hi = 7'h4A; end
			6'd37: begin lo = 7'h6B; hi = 7'h4B; end
			6'd38: begin lo = 7'h6C; hi = 7'h4C; end
			6'd39: begin lo = 7'h3B; hi = 7'h3A; end
			6'd40: begin lo = 7'h27; hi = 7'h22; end
			6'd41: begin lo = 7'h60; hi = 7'h7E; end
			6'd42: begin lo = 7'h30; hi = 7'h30; end
			6'd43: begin lo = 7'h5C; hi = 7'h7C; end
			6'd44: begin lo = 7'h7A; hi = 7'h5A; end
			6'd45: begin lo = 7'h78; hi = 7'h58; end
			6'd46: begin lo = 7'h63; hi = 7'h43; end
			6'd47: begin lo = 7'h76; hi = 7'h56; end
			6'd48: begin lo = 7'h62; hi = 7'h42; end
			6'd49: begin lo = 7'h6E; hi = 7'h4E; end
			6'd50: begin lo = 7'h6D; hi = 7'h4D; end
			6'd51: begin lo = 7'h2C; hi = 7'h3C; end
			6'd52: begin lo = 7'h2E; hi = 7'h3E; end
			6'd53: begin lo = 7'h2F; hi = 7'h3F; end
			6'd54: begin lo = 7'h30; hi = 7'h30; end
			6'd55: begin lo = 7'h2A; hi = 7'h2A; end
			6'd56: begin lo = 7'h30; hi = 7'h30; end
			6'd57: begin lo = 7'h20; hi = 7'h20; end
			6'd58: begin lo = 7'h30; hi = 7'h30; end
			default: begin lo = 7'h00; hi = 7'h00; end
		endcase
		return shifted ? hi : lo;
	endfunction

endpackage

>>> rtl/core/sc2a_cmd_if.sv
// ----------------------------------------------------------------------------
// sc2a_cmd_if
// Command channel: mode, scan code byte and line store read index.
// ----------------------------------------------------------------------------
interface sc2a_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] scan_code;
	logic [6:0] read_index;

	modport source (output valid, output mode, output scan_code, output read_index,
		input ready);
	modport sink (input valid, input mode, input scan_code, input read_index,
		output ready);
endinterface

>>> rtl/core/sc2a_res_if.sv
// ----------------------------------------------------------------------------
// sc2a_res_if
// Result channel: echo, screen clear, terminal switch, line status, read data.
// ----------------------------------------------------------------------------
interface sc2a_res_if;
	logic       valid;
	logic       ready;
	logic       echo_valid;
	logic [6:0] echo_char;
	logic       clear_screen;
	logic       switch_valid;
	logic [1:0] switch_target;
	logic       ready_flag;
	logic [6:0] read_data;

	modport source (output valid, output echo_valid, output echo_char,
		output clear_screen, output switch_valid, output switch_target,
		output ready_flag, output read_data, input ready);
	modport sink (input valid, input echo_valid, input echo_char,
		input clear_screen, input switch_valid, input switch_target,
		input ready_flag, input read_data, output ready);
endinterface

>>> rtl/core/sc2a_ram.sv
// ----------------------------------------------------------------------------
// sc2a_ram
// Generic single write port, single read port RAM with registered read data
// that holds while no read is enabled.
// ----------------------------------------------------------------------------
module sc2a_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/sc2a_keydec.sv
// ----------------------------------------------------------------------------
// sc2a_keydec
// Modifier key tracking and scan code decode into one key event.
// ----------------------------------------------------------------------------
module sc2a_keydec
	import sc2a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       scan,
	input  logic       step,
	input  logic [7:0] code,
	output key_evt_t   evt
);

	logic lshift_q, rshift_q, ctrl_q, caps_q, alt_q;
	logic lshift_d, rshift_d, ctrl_d, caps_d, alt_d;
	logic shifted;
	logic in_map;

	// decode and next modifier state
	always_comb begin
		lshift_d = lshift_q;
		rshift_d = rshift_q;
		ctrl_d   = ctrl_q;
		caps_d   = caps_q;
		alt_d    = alt_q;
		evt      = '0;
		in_map   = code >= CODE_MAP_FIRST && code < CODE_MAP_SIZE && code != CODE_TAB_DOWN;
		shifted  = (lshift_q | rshift_q) ^ (caps_q & is_letter(code[5:0]));
		if (scan) begin
			priority if (code == CODE_CTRL_DOWN) begin
				ctrl_d = 1'b1;
			end else if (code == CODE_CTRL_UP) begin
				ctrl_d = 1'b0;
			end else if (code == CODE_LSHIFT_DOWN) begin
				lshift_d = 1'b1;
			end else if (code == CODE_LSHIFT_UP) begin
				lshift_d = 1'b0;
			end else if (code == CODE_RSHIFT_DOWN) begin
				rshift_d = 1'b1;
			end else if (code == CODE_RSHIFT_UP) begin
				rshift_d = 1'b0;
			end else if (code == CODE_ALT_DOWN) begin
				alt_d = 1'b1;
			end else if (code == CODE_ALT_UP) begin
				alt_d = 1'b0;
			end else if (code == CODE_CAPS_DOWN) begin
				caps_d = ~caps_q;
			end else if (code == CODE_BKSP_DOWN) begin
				evt.bksp = 1'b1;
			end else if (code >= CODE_F1_DOWN && code <= CODE_F3_DOWN) begin
				evt.sw_valid  = alt_q;
				evt.sw_target = alt_q ? 2'(code - CODE_F1_DOWN) : 2'd0;
			end else if (in_map) begin
				if (ctrl_q && key_map(code[5:0], 1'b0) == CH_L) begin
					evt.clear = 1'b1;
					ctrl_d    = 1'b0;
				end else begin
					evt.is_char = 1'b1;
					evt.ch      = key_map(code[5:0], shifted);
				end
			end else begin
				evt = '0;
			end
		end
	end

	// modifier registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			ctrl_q   <= 1'b0;
			caps_q   <= 1'b0;
			alt_q    <= 1'b0;
		end else if (step) begin
			lshift_q <= lshift_d;
			rshift_q <= rshift_d;
			ctrl_q   <= ctrl_d;
			caps_q   <= caps_d;
			alt_q    <= alt_d;
		end
	end

`ifndef SYNTHESIS
	a_clear_drops_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		step && evt.clear |=> !ctrl_q)
		else $error("ctrl still held after screen clear");
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({evt.is_char, evt.bksp, evt.clear, evt.sw_valid}) <= 1)
		else $error("more than one key event decoded");
	a_caps_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		step && code == CODE_CAPS_DOWN |=> caps_q != $past(caps_q))
		else $error("caps lock did not toggle");
`endif

endmodule

>>> rtl/core/sc2a_line.sv
// ----------------------------------------------------------------------------
// sc2a_line
// Line store with write position and ready flag: enters characters,
// handles backspace and newline, serves reads and line consume.
// ----------------------------------------------------------------------------
module sc2a_line
	import sc2a_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [1:0] mode,
	input  logic [6:0] read_index,
	input  key_evt_t   evt,
	output line_res_t  res,
	output logic [6:0] rdata
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int IW = (AW + 1 > 7) ? AW + 1 : 7;
	localparam logic [AW-1:0] LAST = AW'(LINE_DEPTH - 1);
	localparam logic [IW-1:0] DEPTH_W = IW'(LINE_DEPTH);

	logic [AW-1:0] pos_q, pos_d;
	logic          ready_q, ready_d;
	logic          we;
	logic [IW-1:0] idx_ext;
	logic          do_read;

	// editing decisions for the current transaction
	always_comb begin
		pos_d          = pos_q;
		ready_d        = ready_q;
		we             = 1'b0;
		res.echo_valid = 1'b0;
		res.echo_char  = 7'd0;
		if (mode == MODE_CONSUME) begin
			ready_d = 1'b0;
		end else if (evt.bksp) begin
			if (pos_q != '0) begin
				res.echo_valid = 1'b1;
				res.echo_char  = CH_BS;
				pos_d          = pos_q - AW'(1);
			end
		end else if (evt.is_char) begin
			res.echo_valid = 1'b1;
			res.echo_char  = evt.ch;
			// last slot only takes a newline
			we = (pos_q != LAST) || (evt.ch == CH_NL);
			if (evt.ch == CH_NL) begin
				pos_d   = '0;
				ready_d = 1'b1;
			end else if (pos_q != LAST) begin
				pos_d = pos_q + AW'(1);
			end
		end
		res.line_ready = ready_d;
		// read range check
		res.read_sel   = (mode == MODE_READ) && (idx_ext < DEPTH_W);
	end

	// read address
	assign idx_ext = IW'(read_index);
	assign do_read = step && (mode == MODE_READ);

	// position and ready flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			ready_q <= 1'b0;
		end else if (step) begin
			pos_q   <= pos_d;
			ready_q <= ready_d;
		end
	end

	sc2a_ram #(
		.WIDTH(7),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (step && we),
		.waddr(pos_q),
		.wdata(evt.ch),
		.re   (do_read),
		.raddr(idx_ext[AW-1:0]),
		.rdata(rdata)
	);

`ifndef SYNTHESIS
	a_consume_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && mode == MODE_CONSUME |=> !ready_q)
		else $error("line ready after consume");
	a_newline_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		step && evt.is_char && evt.ch == CH_NL |=> pos_q == '0 && ready_q)
		else $error("newline did not complete the line");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST)
		else $error("write position beyond line store");
`endif

endmodule

>>> rtl/core/scan_code_to_ascii_line_editor.sv
// ----------------------------------------------------------------------------
// scan_code_to_ascii_line_editor
// Scan code set 1 to ASCII line editor with a line store.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command per transaction: mode 0 feeds a scan code byte,
//   mode 1 reads the line store at read_index, mode 2 consumes the line.
//   res returns exactly one result transaction per command, in order:
//   echo character, screen clear, terminal switch, line ready flag and the
//   read character.
// Timing:
//   a command accepted into the input register passes through the decode and
//   line store access to the result register, whose line store read uses the
//   RAM's registered port. One command per cycle is sustained while res is
//   not held off.
// Reset:
//   arst_n clears the modifier keys, write position and ready flag; the line
//   store contents are not cleared and must be written before they are read.
// Stall:
//   while res is held off, the result register keeps its transaction and the
//   input register fills, after which cmd.ready drops until res moves.
// ----------------------------------------------------------------------------
module scan_code_to_ascii_line_editor
	import sc2a_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sc2a_cmd_if.sink   cmd,
	sc2a_res_if.source res
);

	logic       valid_s1;
	logic [1:0] mode_s1;
	logic [7:0] code_s1;
	logic [6:0] index_s1;

	logic       valid_s2;
	logic       echo_valid_s2;
	logic [6:0] echo_char_s2;
	logic       clear_s2;
	logic       sw_valid_s2;
	logic [1:0] sw_target_s2;
	logic       ready_flag_s2;
	logic       read_sel_s2;

	logic       adv;
	logic       scan;
	key_evt_t   evt;
	line_res_t  lres;
	logic [6:0] rdata;

	// handshake
	assign adv       = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || adv;
	assign scan      = mode_s1 == MODE_SCAN;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			mode_s1  <= cmd.mode;
			code_s1  <= cmd.scan_code;
			index_s1 <= cmd.read_index;
		end
	end

	sc2a_keydec u_keydec (
		.clk   (clk),
		.arst_n(arst_n),
		.scan  (scan),
		.step  (adv && scan),
		.code  (code_s1),
		.evt   (evt)
	);

	sc2a_line #(
		.LINE_DEPTH(LINE_DEPTH)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.mode      (mode_s1),
		.read_index(index_s1),
		.evt       (evt),
		.res       (lres),
		.rdata     (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || res.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			echo_valid_s2 <= lres.echo_valid;
			echo_char_s2  <= lres.echo_char;
			clear_s2      <= evt.clear;
			sw_valid_s2   <= evt.sw_valid;
			sw_target_s2  <= evt.sw_target;
			ready_flag_s2 <= lres.line_ready;
			read_sel_s2   <= lres.read_sel;
		end
	end

	// outputs
	assign res.valid         = valid_s2;
	assign res.echo_valid    = echo_valid_s2;
	assign res.echo_char     = echo_char_s2;
	assign res.clear_screen  = clear_s2;
	assign res.switch_valid  = sw_valid_s2;
	assign res.switch_target = sw_target_s2;
	assign res.ready_flag    = ready_flag_s2;
	assign res.read_data     = read_sel_s2 ? rdata : 7'd0;

`ifndef SYNTHESIS
	a_echo_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(echo_valid_s2 && (sw_valid_s2 || clear_s2)))
		else $error("echo together with another key action");
	a_target_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !sw_valid_s2 |-> sw_target_s2 == 2'd0)
		else $error("switch target without switch request");
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(code_s1) && $stable(mode_s1))
		else $error("pending command lost while stalled");
`endif

endmodule
